/* design/abd_pkg.sv */
// ----------------------------------------------------------------------------
// abd_pkg
// Shared constants and types for the anchor box decoder: fixed-point
// constants, register indexes and the side-band record of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_VAR_X = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_VAR_Y = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_VAR_W = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_VAR_H = 8'd3;

  // Variance reset values, unsigned Q2.14
  localparam logic [15:0] VAR_XY_RST = 16'd1638;
  localparam logic [15:0] VAR_WH_RST = 16'd3277;

  // Fixed-point constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam logic [30:0] HALF_CAP  = 31'd1073741824;

  // Horner evaluation of exp(u): degree and stages per term
  localparam int unsigned HornerTerms = 8;
  localparam int unsigned StepLat     = 3;
  localparam int unsigned HornerLat   = HornerTerms * StepLat;

  // Widths of internal values
  localparam int unsigned UW = 30;  // u, Q30 fraction of ln2
  localparam int unsigned PW = 32;  // Horner accumulator, Q30

  // Side-band data that rides along the exponent pipeline
  typedef struct packed {
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [7:0]  kw;
    logic signed [7:0]  kh;
    logic [23:0]        aw;
    logic [23:0]        ah;
  } side_t;

  // Saturated corner and its clip flag
  typedef struct packed {
    logic [24:0] val;
    logic        clip;
  } corner_t;

endpackage : abd_pkg

`default_nettype wire

/* design/abd_exp_step.sv */
// ----------------------------------------------------------------------------
// abd_exp_step
// One Horner term of the exp series: p_o = 1 + floor(round(u*p / 2^30) / N),
// in three register stages (multiply, round and reciprocal, correction).
// ----------------------------------------------------------------------------
`default_nettype none

module abd_exp_step
  import abd_pkg::*;
#(
  parameter int unsigned N = 1
) (
  input  wire logic          clk_i,
  input  wire logic [UW-1:0] u_i,
  input  wire logic [PW-1:0] p_i,
  output logic      [UW-1:0] u_o,
  output logic      [PW-1:0] p_o
);

  localparam bit          IsPow2 = ((N & (N - 1)) == 0);
  localparam int unsigned Sh     = $clog2(N);
  localparam int unsigned RecipS = 34;
  localparam logic [33:0] Recip  = 34'((64'd1 << RecipS) / N);
  localparam logic [2:0]  NDiv   = 3'(N);

  logic [UW+PW-1:0] prod_q;
  logic [UW-1:0]    u_a_q, u_b_q, u_c_q;
  logic [PW-1:0]    q_d, q_q;
  logic [PW-1:0]    t;
  logic [PW-1:0]    p_q;

  // Stage a: u * p
  always_ff @(posedge clk_i) begin
    prod_q <= {{PW{1'b0}}, u_i} * {{UW{1'b0}}, p_i};
    u_a_q  <= u_i;
  end

  // Stage b: round back to Q30
  assign q_d = PW'((prod_q + (UW+PW)'(64'd1 << 29)) >> 30);

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    u_b_q <= u_a_q;
  end

  // Stage c: quotient by N, then add one
  if (IsPow2) begin : g_shift
    assign t = q_q >> Sh;
  end else begin : g_recip
    logic [PW+33:0] tprod_q;
    logic [PW-1:0]  t0;
    logic [PW+2:0]  rem;

    // reciprocal product formed alongside q in stage b
    always_ff @(posedge clk_i) begin
      tprod_q <= {34'b0, q_d} * {{PW{1'b0}}, Recip};
    end

    // estimate is low by at most one
    assign t0  = tprod_q[PW+33:RecipS];
    assign rem = {3'b0, q_q} - ({3'b0, t0} * {{PW{1'b0}}, NDiv});
    assign t   = (rem >= (PW+3)'(NDiv)) ? t0 + 1'b1 : t0;
  end

  always_ff @(posedge clk_i) begin
    p_q   <= ONE_Q30 + t;
    u_c_q <= u_b_q;
  end

  assign p_o = p_q;
  assign u_o = u_c_q;

endmodule : abd_exp_step

`default_nettype wire

/* design/anchor_box_decode_core.sv */
// ----------------------------------------------------------------------------
// anchor_box_decode_core
// Throughput: one box per cycle; busy_o never rises, the pipeline never stalls.
// Most of the depth is the exp unit: eight Horner terms of three stages each.
// Reset clears the valid bits and loads the default variances.
// ----------------------------------------------------------------------------
`default_nettype none

module anchor_box_decode_core
  import abd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // box requests
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [15:0] delta_x_i,
  input  wire logic signed [15:0] delta_y_i,
  input  wire logic signed [15:0] delta_w_i,
  input  wire logic signed [15:0] delta_h_i,
  input  wire logic [23:0]        anchor_x_center_i,
  input  wire logic [23:0]        anchor_y_center_i,
  input  wire logic [23:0]        anchor_width_i,
  input  wire logic [23:0]        anchor_height_i,
  // results
  output logic                    done_o,
  output logic signed [24:0]      x_min_o,
  output logic signed [24:0]      y_min_o,
  output logic signed [24:0]      x_max_o,
  output logic signed [24:0]      y_max_o,
  output logic                    saturated_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int unsigned Lat = 8 + HornerLat;

  // Configuration registers
  logic [15:0] var_x_q, var_y_q, var_w_q, var_h_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_x_q <= VAR_XY_RST;
      var_y_q <= VAR_XY_RST;
      var_w_q <= VAR_WH_RST;
      var_h_q <= VAR_WH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VAR_X: var_x_q <= cfg_data_i;
        CFG_VAR_Y: var_y_q <= cfg_data_i;
        CFG_VAR_W: var_w_q <= cfg_data_i;
        CFG_VAR_H: var_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i & ~busy_o};
    end
  end

  assign done_o = vld_q[Lat-1];

  // Stage 1: delta times variance, Q6.26
  logic signed [31:0] s1_ex_q, s1_ey_q, s1_ew_q, s1_eh_q;
  logic [23:0] s1_ax_q, s1_ay_q, s1_aw_q, s1_ah_q;

  always_ff @(posedge clk_i) begin
    s1_ex_q <= $signed({{16{delta_x_i[15]}}, delta_x_i}) * $signed({16'b0, var_x_q});
    s1_ey_q <= $signed({{16{delta_y_i[15]}}, delta_y_i}) * $signed({16'b0, var_y_q});
    s1_ew_q <= $signed({{16{delta_w_i[15]}}, delta_w_i}) * $signed({16'b0, var_w_q});
    s1_eh_q <= $signed({{16{delta_h_i[15]}}, delta_h_i}) * $signed({16'b0, var_h_q});
    s1_ax_q <= anchor_x_center_i;
    s1_ay_q <= anchor_y_center_i;
    s1_aw_q <= anchor_width_i;
    s1_ah_q <= anchor_height_i;
  end

  // Stage 2: center offset products and log2 scaling
  logic signed [55:0] s2_pcx_q, s2_pcy_q;
  logic signed [62:0] s2_pew_q, s2_peh_q;
  logic [23:0] s2_ax_q, s2_ay_q, s2_aw_q, s2_ah_q;

  always_ff @(posedge clk_i) begin
    s2_pcx_q <= $signed({{24{s1_ex_q[31]}}, s1_ex_q}) * $signed({32'b0, s1_aw_q});
    s2_pcy_q <= $signed({{24{s1_ey_q[31]}}, s1_ey_q}) * $signed({32'b0, s1_ah_q});
    s2_pew_q <= $signed({{31{s1_ew_q[31]}}, s1_ew_q}) * $signed({32'b0, LOG2E_Q30});
    s2_peh_q <= $signed({{31{s1_eh_q[31]}}, s1_eh_q}) * $signed({32'b0, LOG2E_Q30});
    s2_ax_q  <= s1_ax_q;
    s2_ay_q  <= s1_ay_q;
    s2_aw_q  <= s1_aw_q;
    s2_ah_q  <= s1_ah_q;
  end

  // Stage 3: centers, integer and fraction of the log2 exponent
  // rounding half away from zero: floor((v + h - [v<0]) / 2^s)
  logic signed [55:0] offx, offy;
  logic signed [62:0] yw, yh;
  side_t       s3_side_d, s3_side_q;
  logic [25:0] s3_fw_q, s3_fh_q;

  assign offx = (s2_pcx_q + 56'sd33554432 - $signed(56'(s2_pcx_q[55]))) >>> 26;
  assign offy = (s2_pcy_q + 56'sd33554432 - $signed(56'(s2_pcy_q[55]))) >>> 26;
  assign yw   = (s2_pew_q + 63'sd536870912 - $signed(63'(s2_pew_q[62]))) >>> 30;
  assign yh   = (s2_peh_q + 63'sd536870912 - $signed(63'(s2_peh_q[62]))) >>> 30;

  always_comb begin
    s3_side_d.cx = $signed({9'b0, s2_ax_q}) + offx[32:0];
    s3_side_d.cy = $signed({9'b0, s2_ay_q}) + offy[32:0];
    s3_side_d.kw = yw[33:26];
    s3_side_d.kh = yh[33:26];
    s3_side_d.aw = s2_aw_q;
    s3_side_d.ah = s2_ah_q;
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= s3_side_d;
    s3_fw_q   <= yw[25:0];
    s3_fh_q   <= yh[25:0];
  end

  // Stage 4: fraction times ln2
  logic [55:0] s4_pw_q, s4_ph_q;
  side_t       s4_side_q;

  always_ff @(posedge clk_i) begin
    s4_pw_q   <= {30'b0, s3_fw_q} * {26'b0, LN2_Q30};
    s4_ph_q   <= {30'b0, s3_fh_q} * {26'b0, LN2_Q30};
    s4_side_q <= s3_side_q;
  end

  // Stage 5: u in Q30
  logic [55:0]   uw_sum, uh_sum;
  logic [UW-1:0] s5_uw_q, s5_uh_q;
  side_t         s5_side_q;

  assign uw_sum = s4_pw_q + 56'd33554432;
  assign uh_sum = s4_ph_q + 56'd33554432;

  always_ff @(posedge clk_i) begin
    s5_uw_q   <= uw_sum[55:26];
    s5_uh_q   <= uh_sum[55:26];
    s5_side_q <= s4_side_q;
  end

  // Horner chain for 2^f, one lane per size
  logic [UW-1:0] u_w [0:HornerTerms];
  logic [UW-1:0] u_h [0:HornerTerms];
  logic [PW-1:0] p_w [0:HornerTerms];
  logic [PW-1:0] p_h [0:HornerTerms];

  assign u_w[0] = s5_uw_q;
  assign u_h[0] = s5_uh_q;
  assign p_w[0] = ONE_Q30;
  assign p_h[0] = ONE_Q30;

  for (genvar i = 0; i < HornerTerms; i++) begin : g_horner
    abd_exp_step #(
      .N (HornerTerms - i)
    ) u_step_w (
      .clk_i (clk_i),
      .u_i   (u_w[i]),
      .p_i   (p_w[i]),
      .u_o   (u_w[i+1]),
      .p_o   (p_w[i+1])
    );
    abd_exp_step #(
      .N (HornerTerms - i)
    ) u_step_h (
      .clk_i (clk_i),
      .u_i   (u_h[i]),
      .p_i   (p_h[i]),
      .u_o   (u_h[i+1]),
      .p_o   (p_h[i+1])
    );
  end

  // side-band delay line matching the Horner chain
  side_t side_q [0:HornerLat-1];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s5_side_q;
    for (int j = 1; j < HornerLat; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // Stage 30: anchor size times 2^f
  logic [55:0] s30_vw_q, s30_vh_q;
  side_t       s30_side_q;

  always_ff @(posedge clk_i) begin
    s30_vw_q   <= {32'b0, side_q[HornerLat-1].aw} * {24'b0, p_w[HornerTerms]};
    s30_vh_q   <= {32'b0, side_q[HornerLat-1].ah} * {24'b0, p_h[HornerTerms]};
    s30_side_q <= side_q[HornerLat-1];
  end

  // Stage 31: scale by 2^k and halve, with cap
  function automatic logic [31:0] half_of(input logic [55:0] v, input logic signed [7:0] k,
                                          input logic [23:0] a);
    logic [7:0]  sm1;
    logic [55:0] vr;
    logic [56:0] r;
    logic [31:0] res;
    sm1 = 8'd30 - k;
    vr  = v >> sm1[5:0];
    r   = ({1'b0, vr} + 57'd1) >> 1;
    priority if (a == '0) begin
      res = '0;
    end else if (k >= 8'sd31) begin
      res = {1'b1, HALF_CAP};
    end else if (k <= -8'sd32) begin
      res = '0;
    end else if (r > 57'(HALF_CAP)) begin
      res = {1'b1, HALF_CAP};
    end else begin
      res = {1'b0, r[30:0]};
    end
    return res;
  endfunction

  logic [31:0] hw_res, hh_res;
  logic [30:0] s31_hw_q, s31_hh_q;
  logic        s31_clip_q;
  logic signed [32:0] s31_cx_q, s31_cy_q;

  assign hw_res = half_of(s30_vw_q, s30_side_q.kw, s30_side_q.aw);
  assign hh_res = half_of(s30_vh_q, s30_side_q.kh, s30_side_q.ah);

  always_ff @(posedge clk_i) begin
    s31_hw_q   <= hw_res[30:0];
    s31_hh_q   <= hh_res[30:0];
    s31_clip_q <= hw_res[31] | hh_res[31];
    s31_cx_q   <= s30_side_q.cx;
    s31_cy_q   <= s30_side_q.cy;
  end

  // Stage 32: corners with saturation
  function automatic corner_t sat_corner(input logic signed [33:0] v);
    corner_t c;
    priority if (v > 34'sd16777215) begin
      c.val  = 25'h0FFFFFF;
      c.clip = 1'b1;
    end else if (v < -34'sd16777216) begin
      c.val  = 25'h1000000;
      c.clip = 1'b1;
    end else begin
      c.val  = v[24:0];
      c.clip = 1'b0;
    end
    return c;
  endfunction

  corner_t xmin_c, ymin_c, xmax_c, ymax_c;

  assign xmin_c = sat_corner($signed({s31_cx_q[32], s31_cx_q}) - $signed({3'b0, s31_hw_q}));
  assign ymin_c = sat_corner($signed({s31_cy_q[32], s31_cy_q}) - $signed({3'b0, s31_hh_q}));
  assign xmax_c = sat_corner($signed({s31_cx_q[32], s31_cx_q}) + $signed({3'b0, s31_hw_q}));
  assign ymax_c = sat_corner($signed({s31_cy_q[32], s31_cy_q}) + $signed({3'b0, s31_hh_q}));

  always_ff @(posedge clk_i) begin
    x_min_o     <= xmin_c.val;
    y_min_o     <= ymin_c.val;
    x_max_o     <= xmax_c.val;
    y_max_o     <= ymax_c.val;
    saturated_o <= s31_clip_q | xmin_c.clip | ymin_c.clip | xmax_c.clip | ymax_c.clip;
  end

endmodule : anchor_box_decode_core

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for anchor_box_decode_core. A clocked driver sends box
// requests from a queue with random idle bursts, a clocked monitor checks
// every done_o result against a fixed-point box decoder kept in the bench.
// Variances are reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module tb;
  import abd_pkg::*;

  // Register index outside the register file, must be ignored
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 8'd200;
  localparam longint unsigned QLog2e = 64'd1549082005;
  localparam longint unsigned QLn2   = 64'd744261118;
  localparam longint unsigned QOne   = 64'd1073741824;
  localparam longint          HalfMax = 64'sd1073741824;
  localparam longint          CornHi  = 64'sd16777215;
  localparam longint          CornLo  = -64'sd16777216;
  localparam int unsigned     DrainCycles = 40;
  localparam int unsigned     StallLimit  = 2000;

  typedef struct {
    logic signed [15:0] dx, dy, dw, dh;
    logic [23:0]        ax, ay, aw, ah;
  } box_t;

  typedef struct {
    logic signed [24:0] x0, y0, x1, y1;
    logic               sat;
  } corners_t;

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        val;
  } cfg_wr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [15:0] delta_x_i = '0, delta_y_i = '0, delta_w_i = '0, delta_h_i = '0;
  logic [23:0] anchor_x_center_i = '0, anchor_y_center_i = '0;
  logic [23:0] anchor_width_i = '0, anchor_height_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic busy_o, done_o, saturated_o, cfg_ready_o;
  logic signed [24:0] x_min_o, y_min_o, x_max_o, y_max_o;

  anchor_box_decode_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Bench copy of the variance registers
  logic [15:0] variance [4] = '{VAR_XY_RST, VAR_XY_RST, VAR_WH_RST, VAR_WH_RST};

  box_t     box_queue[$];
  corners_t corner_queue[$];
  cfg_wr_t  cfg_queue[$];
  box_t     cur_box;
  int unsigned gap_left = 0;
  bit idle_on = 1'b1;
  bit failed = 1'b0;
  int unsigned stall_cnt = 0;

  // Divide by 2^s, round to nearest, halves away from zero
  function automatic longint round_div(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Half of exp(e) * a, Q12.12, with the cap at 2^30
  function automatic longint half_extent(longint e, longint unsigned a, inout bit clip);
    longint y, k, s;
    longint unsigned f, u, p, v, mag, kk;
    y = round_div(e * longint'(QLog2e), 30);
    if (y >= 0) begin
      k = y >>> 26;
      f = y & 64'h3FF_FFFF;
    end else begin
      mag = -y;
      kk = (mag + 64'h3FF_FFFF) >> 26;
      k = -longint'(kk);
      f = (kk << 26) - mag;
    end
    u = (f * QLn2 + (64'd1 << 25)) >> 26;
    p = QOne;
    for (int n = 8; n >= 1; n--) p = QOne + ((u * p + (QOne >> 1)) >> 30) / n;
    if (a == 0) return 0;
    v = a * p;
    s = 31 - k;
    if (s <= 0) begin
      clip = 1'b1;
      return HalfMax;
    end
    if (s >= 63) return 0;
    v = (v + (64'd1 << (s - 1))) >> s;
    if (v > HalfMax) begin
      clip = 1'b1;
      return HalfMax;
    end
    return longint'(v);
  endfunction

  function automatic logic signed [24:0] clamp_corner(longint v, inout bit clip);
    if (v > CornHi) begin
      clip = 1'b1;
      return CornHi[24:0];
    end
    if (v < CornLo) begin
      clip = 1'b1;
      return CornLo[24:0];
    end
    return v[24:0];
  endfunction

  function automatic corners_t decode_box(box_t b);
    corners_t r;
    bit clip;
    longint ex, ey, ew, eh, cx, cy, hw, hh;
    clip = 1'b0;
    ex = longint'(b.dx) * longint'({48'd0, variance[CFG_VAR_X]});
    ey = longint'(b.dy) * longint'({48'd0, variance[CFG_VAR_Y]});
    ew = longint'(b.dw) * longint'({48'd0, variance[CFG_VAR_W]});
    eh = longint'(b.dh) * longint'({48'd0, variance[CFG_VAR_H]});
    cx = longint'({40'd0, b.ax}) + round_div(ex * longint'({40'd0, b.aw}), 26);
    cy = longint'({40'd0, b.ay}) + round_div(ey * longint'({40'd0, b.ah}), 26);
    hw = half_extent(ew, {40'd0, b.aw}, clip);
    hh = half_extent(eh, {40'd0, b.ah}, clip);
    r.x0 = clamp_corner(cx - hw, clip);
    r.y0 = clamp_corner(cy - hh, clip);
    r.x1 = clamp_corner(cx + hw, clip);
    r.y1 = clamp_corner(cy + hh, clip);
    r.sat = clip;
    return r;
  endfunction

  // Box request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) corner_queue.push_back(decode_box(cur_box));
      if (start_i && busy_o) begin
        // hold the request
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (box_queue.size() > 0) begin
        cur_box = box_queue.pop_front();
        delta_x_i <= cur_box.dx;
        delta_y_i <= cur_box.dy;
        delta_w_i <= cur_box.dw;
        delta_h_i <= cur_box.dh;
        anchor_x_center_i <= cur_box.ax;
        anchor_y_center_i <= cur_box.ay;
        anchor_width_i <= cur_box.aw;
        anchor_height_i <= cur_box.ah;
        start_i <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 4);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Variance register writer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i <= CFG_VAR_H) variance[cfg_index_i] = cfg_data_i;
        void'(cfg_queue.pop_front());
      end
      if (cfg_valid_i && !cfg_ready_o) begin
        // hold the write
      end else if (cfg_queue.size() > 0 && !(cfg_valid_i && cfg_ready_o && cfg_queue.size() == 0)) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= cfg_queue[0].idx;
        cfg_data_i <= cfg_queue[0].val;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    corners_t want;
    if (rst_ni && done_o) begin
      if (corner_queue.size() == 0) begin
        $error("result with no request pending");
        failed = 1'b1;
      end else begin
        want = corner_queue.pop_front();
        if (x_min_o !== want.x0) begin
          $error("x_min exp %0d got %0d", want.x0, x_min_o);
          failed = 1'b1;
        end
        if (y_min_o !== want.y0) begin
          $error("y_min exp %0d got %0d", want.y0, y_min_o);
          failed = 1'b1;
        end
        if (x_max_o !== want.x1) begin
          $error("x_max exp %0d got %0d", want.x1, x_max_o);
          failed = 1'b1;
        end
        if (y_max_o !== want.y1) begin
          $error("y_max exp %0d got %0d", want.y1, y_max_o);
          failed = 1'b1;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated exp %0b got %0b", want.sat, saturated_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, write or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic box_t rand_box(bit typical);
    box_t b;
    if (typical) begin
      b.dx = 16'($urandom_range(0, 16383) - 8192);
      b.dy = 16'($urandom_range(0, 16383) - 8192);
      b.dw = 16'($urandom_range(0, 16383) - 8192);
      b.dh = 16'($urandom_range(0, 16383) - 8192);
      b.ax = 24'($urandom_range(0, 24'h7F_FFFF));
      b.ay = 24'($urandom_range(0, 24'h7F_FFFF));
      b.aw = 24'($urandom_range(0, 24'h0F_FFFF));
      b.ah = 24'($urandom_range(0, 24'h0F_FFFF));
    end else begin
      b.dx = 16'($urandom);
      b.dy = 16'($urandom);
      b.dw = 16'($urandom);
      b.dh = 16'($urandom);
      b.ax = 24'($urandom);
      b.ay = 24'($urandom);
      b.aw = 24'($urandom);
      b.ah = 24'($urandom);
    end
    return b;
  endfunction

  function automatic box_t make_box(int dx, int dy, int dw, int dh,
                                    int ax, int ay, int aw, int ah);
    box_t b;
    b.dx = 16'(dx); b.dy = 16'(dy); b.dw = 16'(dw); b.dh = 16'(dh);
    b.ax = 24'(ax); b.ay = 24'(ay); b.aw = 24'(aw); b.ah = 24'(ah);
    return b;
  endfunction

  // Wait until the pipeline holds nothing, then let it settle
  task automatic drain();
    while (box_queue.size() > 0 || start_i || corner_queue.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_vars(logic [15:0] vx, logic [15:0] vy, logic [15:0] vw,
                          logic [15:0] vh);
    cfg_queue.push_back('{CFG_VAR_X, vx});
    cfg_queue.push_back('{CFG_VAR_Y, vy});
    cfg_queue.push_back('{CFG_VAR_W, vw});
    cfg_queue.push_back('{CFG_VAR_H, vh});
    cfg_queue.push_back('{CFG_UNUSED, 16'hFFFF});
    while (cfg_queue.size() > 0 || cfg_valid_i) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed boxes at reset variances, then at full-scale variances
    for (int pass = 0; pass < 2; pass++) begin
      box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, 0, 0));
      box_queue.push_back(make_box(32767, 32767, 32767, 32767,
                                   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      box_queue.push_back(make_box(-32768, -32768, -32768, -32768,
                                   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      box_queue.push_back(make_box(-32768, 32767, -32768, 32767, 0, 0, 24'hFFFFFF, 4096));
      box_queue.push_back(make_box(4096, -4096, 0, 0, 4096, 4096, 0, 0));
      box_queue.push_back(make_box(1, -1, 1, -1, 24'h800000, 24'h800000, 1, 1));
      box_queue.push_back(make_box(0, 0, 20000, -20000, 100, 24'hFFFF00, 8192, 8192));
      box_queue.push_back(make_box(0, 0, 0, 0, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF));
      box_queue.push_back(make_box(12000, -12000, 12000, -12000,
                                   24'h100000, 24'h100000, 24'h040000, 24'h040000));
      drain();
      if (pass == 0) set_vars(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    end

    // Random phases over several variance settings
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_vars(VAR_XY_RST, VAR_XY_RST, VAR_WH_RST, VAR_WH_RST);
        1: set_vars(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: set_vars(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        3: set_vars(16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF);
        default: begin
          set_vars(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                   16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)));
          idle_on = 1'b0;
        end
      endcase
      for (int i = 0; i < 290; i++) box_queue.push_back(rand_box($urandom_range(0, 3) != 0));
    end

    drain();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
